// ----- src/piecewise_linear_interpolator_top_defines.svh -----
// assertion macros used by the checker
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH

// condition holds in the same cycle
`define PLIN_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define PLIN_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/plin_pkg.sv -----
package plin_pkg;

    localparam int POINTS    = 64;
    localparam int IDX_W     = $clog2(POINTS);
    localparam int COUNT_W   = 7;
    localparam int DATA_W    = 32;
    localparam int MAG_W     = DATA_W + 1;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int DIV_STEPS = MAG_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        POS_SEGMENT = 2'd0,
        POS_FIRST   = 2'd1,
        POS_LAST    = 2'd2
    } position_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_FIRST,
        ST_SCAN,
        ST_SETUP,
        ST_DIV,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed
    {
        logic             start;
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
        logic [MAG_W-1:0] md;
    } div_req_t;

    typedef struct packed
    {
        logic             done;
        logic [MAG_W-1:0] quot;
    } div_rsp_t;

    // index of the last point in use, count clamped to 1 .. POINTS
    function automatic logic [IDX_W-1:0] active_last(input logic [COUNT_W-1:0] count);
        logic [IDX_W-1:0] last;
        if (count == '0)
        begin
            last = '0;
        end
        else if (count > COUNT_W'(POINTS))
        begin
            last = IDX_W'(POINTS - 1);
        end
        else
        begin
            last = IDX_W'(count - COUNT_W'(1));
        end
        return last;
    endfunction

endpackage

// ----- src/plin_table.sv -----
module plin_table
    import plin_pkg::*;
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_addr,
    input  logic signed [DATA_W-1:0] wr_x,
    input  logic signed [DATA_W-1:0] wr_y,
    input  logic [IDX_W-1:0]         rd_addr,
    output logic signed [DATA_W-1:0] rd_x,
    output logic signed [DATA_W-1:0] rd_y
);

    logic [2*DATA_W-1:0] mem [POINTS];
    logic [2*DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_x, wr_y};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_x = rd_data_reg[2*DATA_W-1:DATA_W];
    assign rd_y = rd_data_reg[DATA_W-1:0];

endmodule

// ----- src/plin_div.sv -----
module plin_div
    import plin_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [MAG_W-1:0]  mx_reg;
    logic [MAG_W-1:0]  my_reg;
    logic [MAG_W-1:0]  md_reg;
    logic              mul_pend_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              done_reg;
    logic [MAG_W-1:0]  rem_reg;
    logic [MAG_W-1:0]  qs_reg;

    logic [PROD_W-1:0] prod;
    logic [MAG_W:0]    trial;
    logic              ge;

    assign prod  = mx_reg * my_reg;
    assign trial = {rem_reg, qs_reg[MAG_W-1]};
    assign ge    = trial >= {1'b0, md_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_pend_reg <= 1'b0;
            cnt_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                mul_pend_reg <= 1'b1;
            end
            else if (mul_pend_reg)
            begin
                mul_pend_reg <= 1'b0;
                cnt_reg      <= STEP_W'(DIV_STEPS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - STEP_W'(1);
                done_reg <= (cnt_reg == STEP_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mx_reg <= req.mx;
            my_reg <= req.my;
            md_reg <= req.md;
        end
        if (mul_pend_reg)
        begin
            // quotient fits MAG_W bits, so the upper half starts below the divisor
            rem_reg <= prod[PROD_W-1:MAG_W];
            qs_reg  <= prod[MAG_W-1:0];
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? MAG_W'(trial - {1'b0, md_reg}) : trial[MAG_W-1:0];
            qs_reg  <= {qs_reg[MAG_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = qs_reg;

endmodule

// ----- src/plin_ctrl.sv -----
module plin_ctrl
    import plin_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     opcode,
    input  logic [5:0]               point_index,
    input  logic signed [DATA_W-1:0] x_value,
    input  logic signed [DATA_W-1:0] y_value,
    input  logic [COUNT_W-1:0]       point_count,
    output logic                     tbl_wr_en,
    output logic [IDX_W-1:0]         tbl_wr_addr,
    output logic signed [DATA_W-1:0] tbl_wr_x,
    output logic signed [DATA_W-1:0] tbl_wr_y,
    output logic [IDX_W-1:0]         tbl_rd_addr,
    input  logic signed [DATA_W-1:0] tbl_rd_x,
    input  logic signed [DATA_W-1:0] tbl_rd_y,
    output div_req_t                 div_req,
    input  div_rsp_t                 div_rsp,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] y_result,
    output logic [1:0]               position
);

    ctrl_state_t              state_reg, state_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [IDX_W-1:0]         last_reg, last_next;
    logic signed [DATA_W-1:0] xq_reg, xq_next;
    logic signed [DATA_W-1:0] first_x_reg, first_x_next;
    logic signed [DATA_W-1:0] first_y_reg, first_y_next;
    logic signed [DATA_W-1:0] x0_reg, x0_next;
    logic signed [DATA_W-1:0] y0_reg, y0_next;
    logic signed [DATA_W-1:0] x1_reg, x1_next;
    logic signed [DATA_W-1:0] y1_reg, y1_next;
    logic                     neg_reg, neg_next;
    logic signed [DATA_W-1:0] res_reg, res_next;
    position_t                pos_reg, pos_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_y_reg, out_y_next;
    position_t                out_pos_reg, out_pos_next;

    logic                     accept;
    logic                     bracket;
    logic signed [DATA_W-1:0] cmp_first_x;
    logic signed [DATA_W-1:0] cmp_first_y;
    logic                     clamp_first;
    logic signed [DATA_W-1:0] clamp_y;
    position_t                clamp_pos;
    logic signed [MAG_W-1:0]  dx;
    logic signed [MAG_W-1:0]  dy;
    logic signed [MAG_W-1:0]  dd;
    logic [MAG_W-1:0]         y_sum;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // ascending or descending segment around the query
    assign bracket = ((x0_reg <= xq_reg) && (tbl_rd_x > xq_reg))
                  || ((x0_reg >= xq_reg) && (tbl_rd_x < xq_reg));

    // clamp against the current entry as the last point
    assign cmp_first_x = (state_reg == ST_FIRST) ? tbl_rd_x : first_x_reg;
    assign cmp_first_y = (state_reg == ST_FIRST) ? tbl_rd_y : first_y_reg;
    assign clamp_first = (xq_reg <= cmp_first_x) && (xq_reg <= tbl_rd_x);
    assign clamp_y     = clamp_first ? cmp_first_y : tbl_rd_y;
    assign clamp_pos   = clamp_first ? POS_FIRST : POS_LAST;

    assign dx = {xq_reg[DATA_W-1], xq_reg} - {x0_reg[DATA_W-1], x0_reg};
    assign dy = {y1_reg[DATA_W-1], y1_reg} - {y0_reg[DATA_W-1], y0_reg};
    assign dd = {x1_reg[DATA_W-1], x1_reg} - {x0_reg[DATA_W-1], x0_reg};

    assign y_sum = neg_reg ? ({y0_reg[DATA_W-1], y0_reg} - div_rsp.quot)
                           : ({y0_reg[DATA_W-1], y0_reg} + div_rsp.quot);

    assign tbl_wr_addr = IDX_W'(point_index);
    assign tbl_wr_x    = x_value;
    assign tbl_wr_y    = y_value;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        xq_next        = xq_reg;
        first_x_next   = first_x_reg;
        first_y_next   = first_y_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_y_next     = out_y_reg;
        out_pos_next   = out_pos_reg;
        tbl_wr_en      = 1'b0;
        tbl_rd_addr    = idx_reg + IDX_W'(1);
        div_req.start  = 1'b0;
        div_req.mx     = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
        div_req.my     = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
        div_req.md     = dd[MAG_W-1] ? MAG_W'(-dd) : MAG_W'(dd);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                tbl_rd_addr = '0;
                if (accept)
                begin
                    if (opcode == OP_WRITE)
                    begin
                        tbl_wr_en = 1'b1;
                    end
                    else
                    begin
                        xq_next    = x_value;
                        last_next  = active_last(point_count);
                        state_next = ST_FIRST;
                    end
                end
            end
            ST_FIRST:
            begin
                first_x_next = tbl_rd_x;
                first_y_next = tbl_rd_y;
                x0_next      = tbl_rd_x;
                y0_next      = tbl_rd_y;
                idx_next     = IDX_W'(1);
                tbl_rd_addr  = IDX_W'(1);
                if (last_reg == '0)
                begin
                    res_next   = clamp_y;
                    pos_next   = clamp_pos;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                priority if (bracket)
                begin
                    x1_next    = tbl_rd_x;
                    y1_next    = tbl_rd_y;
                    state_next = ST_SETUP;
                end
                else if (idx_reg == last_reg)
                begin
                    res_next   = clamp_y;
                    pos_next   = clamp_pos;
                    state_next = ST_EMIT;
                end
                else
                begin
                    x0_next  = tbl_rd_x;
                    y0_next  = tbl_rd_y;
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_SETUP:
            begin
                div_req.start = 1'b1;
                neg_next      = dx[MAG_W-1] ^ dy[MAG_W-1] ^ dd[MAG_W-1];
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_next   = y_sum[DATA_W-1:0];
                    pos_next   = POS_SEGMENT;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_y_next     = res_reg;
                    out_pos_next   = pos_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        last_reg    <= last_next;
        xq_reg      <= xq_next;
        first_x_reg <= first_x_next;
        first_y_reg <= first_y_next;
        x0_reg      <= x0_next;
        y0_reg      <= y0_next;
        x1_reg      <= x1_next;
        y1_reg      <= y1_next;
        neg_reg     <= neg_next;
        res_reg     <= res_next;
        pos_reg     <= pos_next;
        out_y_reg   <= out_y_next;
        out_pos_reg <= out_pos_next;
    end

    assign out_valid = out_valid_reg;
    assign y_result  = out_y_reg;
    assign position  = out_pos_reg;

endmodule

// ----- src/piecewise_linear_interpolator_top.sv -----
// Piecewise linear lookup over up to 64 breakpoints (x, y) in signed Q16.16.
// A write request stores one point. A query request reads the table one
// entry per cycle through the single read port of the point memory,
// stopping at the first segment that brackets x; for that segment it then
// runs a 33 by 33 bit multiply and a radix-2 divider of 33 steps, else it
// clamps to the first or last point. One request is worked on at a time;
// a finished result waits in the output register while the next request
// is taken. point_count may only be written while no request is in
// progress.
module piecewise_linear_interpolator_top
    import plin_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     opcode,
    input  logic [5:0]               point_index,
    input  logic signed [DATA_W-1:0] x_value,
    input  logic signed [DATA_W-1:0] y_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] y_result,
    output logic [1:0]               position,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [COUNT_W-1:0]       cfg_data
);

    logic [COUNT_W-1:0]       point_count_reg;
    logic                     tbl_wr_en;
    logic [IDX_W-1:0]         tbl_wr_addr;
    logic signed [DATA_W-1:0] tbl_wr_x;
    logic signed [DATA_W-1:0] tbl_wr_y;
    logic [IDX_W-1:0]         tbl_rd_addr;
    logic signed [DATA_W-1:0] tbl_rd_x;
    logic signed [DATA_W-1:0] tbl_rd_y;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= COUNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            point_count_reg <= cfg_data;
        end
    end

    plin_table u_table
    (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_x    (tbl_wr_x),
        .wr_y    (tbl_wr_y),
        .rd_addr (tbl_rd_addr),
        .rd_x    (tbl_rd_x),
        .rd_y    (tbl_rd_y)
    );

    plin_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    plin_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .point_index (point_index),
        .x_value     (x_value),
        .y_value     (y_value),
        .point_count (point_count_reg),
        .tbl_wr_en   (tbl_wr_en),
        .tbl_wr_addr (tbl_wr_addr),
        .tbl_wr_x    (tbl_wr_x),
        .tbl_wr_y    (tbl_wr_y),
        .tbl_rd_addr (tbl_rd_addr),
        .tbl_rd_x    (tbl_rd_x),
        .tbl_rd_y    (tbl_rd_y),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .y_result    (y_result),
        .position    (position)
    );

endmodule

// ----- src/plin_checker.sv -----
`include "piecewise_linear_interpolator_top_defines.svh"

module plin_checker
    import plin_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        opcode,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] y_result,
    input logic [1:0]  position
);

    // a query keeps the block busy in the next cycle
    `PLIN_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && opcode == OP_QUERY, in_stall, "query request did not hold input")

    // a write leaves the input free in the next cycle
    `PLIN_ASSERT_NEXT(a_write_done, in_valid && !in_stall && opcode == OP_WRITE, !in_stall, "write request held input")

    // position code stays in range
    `PLIN_ASSERT_NOW(a_pos_code, out_valid, position != 2'd3, "undefined position code")

    // stalled result holds
    `PLIN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(y_result) && $stable(position), "stalled result changed")

endmodule

bind piecewise_linear_interpolator_top plin_checker u_plin_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .y_result  (y_result),
    .position  (position)
);

// ----- bench/tb_piecewise_linear_interpolator_top.sv -----
module tb_piecewise_linear_interpolator_top;
    import plin_pkg::*;

    localparam int ITEM_TARGET   = 750;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 150;
    localparam int REPORT_LIMIT  = 10;

    typedef logic signed [DATA_W-1:0] q16_t;

    localparam q16_t X_MIN = 32'sh8000_0000;
    localparam q16_t X_MAX = 32'sh7FFF_FFFF;

    typedef struct
    {
        q16_t      y;
        position_t pos;
    } lookup_t;

    class interp_scoreboard;
        q16_t               bp_x [POINTS];
        q16_t               bp_y [POINTS];
        logic [COUNT_W-1:0] count;
        lookup_t            due [$];
        int                 writes;
        int                 lookups;
        int                 errors;
        int                 in_segment;
        int                 at_first;
        int                 at_last;

        function new();
            count      = COUNT_W'(1);
            writes     = 0;
            lookups    = 0;
            errors     = 0;
            in_segment = 0;
            at_first   = 0;
            at_last    = 0;
        endfunction

        function int points_in_use();
            if (count == '0)
            begin
                return 1;
            end
            if (count > COUNT_W'(POINTS))
            begin
                return POINTS;
            end
            return int'(count);
        endfunction

        // exact product, quotient truncated toward zero
        function q16_t segment_value(q16_t xq, int k);
            longint            dx;
            longint            dy;
            longint            dd;
            logic [MAG_W-1:0]  mx;
            logic [MAG_W-1:0]  my;
            logic [MAG_W-1:0]  md;
            logic [PROD_W-1:0] prod;
            logic [PROD_W-1:0] quo;
            bit                neg;
            longint            r;
            dx   = longint'(xq) - longint'(bp_x[k-1]);
            dy   = longint'(bp_y[k]) - longint'(bp_y[k-1]);
            dd   = longint'(bp_x[k]) - longint'(bp_x[k-1]);
            neg  = (dx < 0) ^ (dy < 0) ^ (dd < 0);
            mx   = MAG_W'((dx < 0) ? -dx : dx);
            my   = MAG_W'((dy < 0) ? -dy : dy);
            md   = MAG_W'((dd < 0) ? -dd : dd);
            prod = PROD_W'(mx) * PROD_W'(my);
            quo  = prod / PROD_W'(md);
            if (neg)
            begin
                r = longint'(bp_y[k-1]) - longint'(quo[MAG_W-1:0]);
            end
            else
            begin
                r = longint'(bp_y[k-1]) + longint'(quo[MAG_W-1:0]);
            end
            return q16_t'(r[DATA_W-1:0]);
        endfunction

        function lookup_t predict_lookup(q16_t xq);
            lookup_t r;
            int      n;
            n = points_in_use();
            for (int k = 1; k < n; k++)
            begin
                if ((bp_x[k-1] <= xq && bp_x[k] > xq) || (bp_x[k-1] >= xq && bp_x[k] < xq))
                begin
                    r.y   = segment_value(xq, k);
                    r.pos = POS_SEGMENT;
                    return r;
                end
            end
            if (xq <= bp_x[0] && xq <= bp_x[n-1])
            begin
                r.y   = bp_y[0];
                r.pos = POS_FIRST;
            end
            else
            begin
                r.y   = bp_y[n-1];
                r.pos = POS_LAST;
            end
            return r;
        endfunction

        function void note_request(opcode_t op, logic [5:0] idx, q16_t xq, q16_t yq);
            if (op == OP_WRITE)
            begin
                bp_x[idx] = xq;
                bp_y[idx] = yq;
                writes++;
            end
            else
            begin
                due.push_back(predict_lookup(xq));
                lookups++;
            end
        endfunction

        function void check_result(q16_t y, position_t pos);
            lookup_t e;
            if (due.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("unexpected lookup result y=%h position=%0d", y, pos);
                end
                return;
            end
            e = due.pop_front();
            case (e.pos)
                POS_SEGMENT: in_segment++;
                POS_FIRST:   at_first++;
                default:     at_last++;
            endcase
            if (y !== e.y || pos !== e.pos)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("lookup mismatch: y expected %h got %h, position expected %0d got %0d",
                             e.y, y, e.pos, pos);
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 opcode;
    logic [5:0]           point_index;
    q16_t                 x_value;
    q16_t                 y_value;
    logic                 out_valid;
    logic                 out_stall;
    q16_t                 y_result;
    logic [1:0]           position;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [COUNT_W-1:0]   cfg_data;

    interp_scoreboard sb;
    int               sent;
    int               settings;
    int               cycles;
    int               phase;
    int               cnt;
    int               n;
    int               len;
    bit               calm;
    int               phase_counts [9] = '{2, 64, 127, 1, 0, 65, 40, 64, 5};

    piecewise_linear_interpolator_top uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .point_index (point_index),
        .x_value     (x_value),
        .y_value     (y_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .y_result    (y_result),
        .position    (position),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d lookups still due", cycles, sb.due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 7);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(y_result, position_t'(position));
        end
    end

    task automatic send_request(opcode_t op, logic [5:0] idx, q16_t xq, q16_t yq);
        while (!calm && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        point_index <= idx;
        x_value     <= xq;
        y_value     <= yq;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_request(op, idx, xq, yq);
        sent++;
    endtask

    // point count changes only once the block has drained
    task automatic write_count(logic [COUNT_W-1:0] v);
        in_valid <= 1'b0;
        while (sb.due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        sb.count = v;
        settings++;
    endtask

    function automatic q16_t pick_y();
        if ($urandom_range(0, 3) == 0)
        begin
            return q16_t'(int'($urandom_range(0, 262144)) - 131072);
        end
        return q16_t'($urandom);
    endfunction

    function automatic q16_t pick_query_x(int pts);
        int     sel;
        int     k;
        longint lo;
        longint hi;
        longint span;
        sel = $urandom_range(0, 19);
        if (sel < 10 && pts > 1)
        begin
            k  = $urandom_range(1, pts - 1);
            lo = longint'(sb.bp_x[k-1]);
            hi = longint'(sb.bp_x[k]);
            if (lo > hi)
            begin
                span = lo;
                lo   = hi;
                hi   = span;
            end
            span = hi - lo + 1;
            return q16_t'(lo + longint'({$urandom, $urandom} % 64'(span)));
        end
        if (sel < 13)
        begin
            return sb.bp_x[$urandom_range(0, pts - 1)];
        end
        if (sel < 15)
        begin
            return $urandom_range(0, 1) ? X_MAX : X_MIN;
        end
        return q16_t'($urandom);
    endfunction

    // breakpoints in use, mostly sorted either way, sometimes shuffled noise
    task automatic fill_table(int pts, int style);
        int     xs [$];
        int     order [$];
        longint base;
        longint step;
        base = longint'($urandom_range(0, 2097152)) - 1048576;
        step = longint'($urandom_range(1, 131072));
        for (int i = 0; i < pts; i++)
        begin
            if (style == 2 || style == 3)
            begin
                xs.push_back(int'(base + i * step));
                if (i > 0 && $urandom_range(0, 7) == 0)
                begin
                    xs[i] = xs[i-1];
                end
            end
            else
            begin
                xs.push_back(int'($urandom));
            end
            order.push_back(i);
        end
        if (style == 0 || style == 2)
        begin
            xs.sort();
        end
        else if (style == 1 || style == 3)
        begin
            if (style == 1)
            begin
                xs.rsort();
            end
            else
            begin
                xs.reverse();
            end
        end
        order.shuffle();
        foreach (order[j])
        begin
            send_request(OP_WRITE, 6'(order[j]), q16_t'(xs[order[j]]), pick_y());
        end
    endtask

    initial
    begin
        sb          = new();
        sent        = 0;
        settings    = 0;
        cycles      = 0;
        phase       = 0;
        calm        = 1'b0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        opcode      <= OP_WRITE;
        point_index <= '0;
        x_value     <= '0;
        y_value     <= '0;
        out_stall   <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single point table at reset count
        send_request(OP_WRITE, 6'd0, 32'sh0000_0000, 32'sh0001_0000);
        send_request(OP_QUERY, 6'd63, -32'sd1, 32'sh7FFF_FFFF);
        send_request(OP_QUERY, 6'd0, 32'sh0000_0000, 32'sh0000_0000);
        send_request(OP_QUERY, 6'd21, X_MAX, X_MIN);

        // zero count behaves as one point
        write_count(COUNT_W'(0));
        send_request(OP_QUERY, 6'd42, X_MIN, 32'sh0000_0000);
        send_request(OP_QUERY, 6'd0, 32'sh0000_0001, 32'sh0000_0000);

        // full-scale segments, largest products
        send_request(OP_WRITE, 6'd0, X_MIN, X_MIN);
        send_request(OP_WRITE, 6'd1, 32'sh0000_0000, X_MAX);
        send_request(OP_WRITE, 6'd2, X_MAX, X_MIN);
        write_count(COUNT_W'(3));
        send_request(OP_QUERY, 6'd0, X_MIN, 32'sh0000_0000);
        send_request(OP_QUERY, 6'd0, -32'sd1, 32'sh0000_0000);
        send_request(OP_QUERY, 6'd0, 32'sh0000_0000, 32'sh0000_0000);
        send_request(OP_QUERY, 6'd0, X_MAX - 1, 32'sh0000_0000);
        send_request(OP_QUERY, 6'd0, X_MAX, 32'sh0000_0000);

        // descending segment then a zero-length one
        send_request(OP_WRITE, 6'd0, 32'sh0003_0000, 32'sd7);
        send_request(OP_WRITE, 6'd1, -32'sh0003_0000, -32'sd7);
        send_request(OP_WRITE, 6'd2, -32'sh0003_0000, 32'sd9);
        send_request(OP_QUERY, 6'd0, 32'sh0000_0000, 32'sh0000_0000);
        send_request(OP_QUERY, 6'd0, -32'sh0003_0000, 32'sh0000_0000);
        send_request(OP_QUERY, 6'd0, 32'sh0004_0000, 32'sh0000_0000);
        send_request(OP_QUERY, 6'd0, 32'sh0002_FFFF, 32'sh0000_0000);

        while (sent < ITEM_TARGET)
        begin
            if (phase < $size(phase_counts))
            begin
                cnt = phase_counts[phase];
            end
            else
            begin
                cnt = $urandom_range(0, 127);
            end
            calm = (phase == 2);
            write_count(COUNT_W'(cnt));
            n = sb.points_in_use();
            fill_table(n, $urandom_range(0, 4));
            len = $urandom_range(40, 70);
            repeat (len)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_request(OP_WRITE, 6'($urandom), q16_t'($urandom), pick_y());
                end
                else
                begin
                    send_request(OP_QUERY, 6'($urandom), pick_query_x(n), q16_t'($urandom));
                end
            end
            phase++;
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        while (sb.due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests over %0d point-count settings: %0d table writes, %0d lookups",
                 sent, settings, sb.writes, sb.lookups);
        $display("lookups inside a segment %0d, held at first point %0d, at last point %0d, errors %0d",
                 sb.in_segment, sb.at_first, sb.at_last, sb.errors);
        if (sb.errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
